// ----- hw/rtl/kbmc_pkg.sv -----
// ----------------------------------------------------------------------------
// kbmc_pkg: shared types and constants of the knob and button menu controller
// Holds event codes, menu state codes, limits and the item and result structs.
// ----------------------------------------------------------------------------
package kbmc_pkg;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_ENC   = 3'd1;
  localparam logic [2:0] MODE_BTN   = 3'd2;
  localparam logic [2:0] MODE_STATE = 3'd3;
  localparam logic [2:0] MODE_LOAD  = 3'd4;

  localparam logic [3:0] ST_OFF       = 4'd0;
  localparam logic [3:0] ST_SET_TEMP  = 4'd1;
  localparam logic [3:0] ST_SET_TIME  = 4'd2;
  localparam logic [3:0] ST_SET_TIMER = 4'd3;
  localparam logic [3:0] ST_READY     = 4'd4;
  localparam logic [3:0] ST_HEATING   = 4'd5;
  localparam logic [3:0] ST_SOAKING   = 4'd6;
  localparam logic [3:0] ST_DONE      = 4'd7;
  localparam logic [3:0] ST_STOPPED   = 4'd8;
  localparam logic [3:0] ST_ERROR     = 4'd9;

  localparam logic CFG_DEBOUNCE   = 1'b0;
  localparam logic CFG_LONG_PRESS = 1'b1;

  localparam logic [7:0]  TEMP_MIN   = 8'd50;
  localparam logic [7:0]  TEMP_MAX   = 8'd200;
  localparam logic [7:0]  TEMP_RESET = 8'd100;
  localparam logic [11:0] SOAK_MAX   = 12'd3600;
  localparam logic [9:0]  DEBOUNCE_RESET   = 10'd50;
  localparam logic [13:0] LONG_PRESS_RESET = 14'd2000;
  localparam logic [15:0] SAT16 = 16'hFFFF;

  // Reciprocal of 60 scaled by 2^18, exact for every 12-bit soak time.
  localparam logic [12:0] RECIP_60 = 13'd4370;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  enc_delta;
    logic        button_down;
    logic        soak_running;
    logic [3:0]  new_state;
    logic [7:0]  load_temp;
    logic [11:0] load_soak_seconds;
    logic        load_timer_enabled;
  } item_t;

  typedef struct packed {
    logic short_beep;
    logic long_beep;
    logic save_settings;
    logic start_heating;
    logic restart_soak;
    logic stop_heating;
  } pulses_t;

  typedef struct packed {
    logic [3:0]  ui_state;
    logic [7:0]  target_temp;
    logic [11:0] soak_seconds;
    logic        timer_enabled;
    pulses_t     pulses;
  } result_t;

endpackage

// ----- hw/rtl/kbmc_core.sv -----
// ----------------------------------------------------------------------------
// kbmc_core: menu state and event update
// Holds the settings, the press tracking and the configuration registers, and
// computes the result of one item from the current state.
// ----------------------------------------------------------------------------
module kbmc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [13:0]      cfg_wdata,
  input  logic             step,
  input  kbmc_pkg::item_t   item,
  output kbmc_pkg::result_t res
);
  import kbmc_pkg::*;

  logic [9:0]  debounce_r;
  logic [13:0] long_press_r;
  logic [3:0]  ui_mode_r, ui_mode_nxt;
  logic [7:0]  temp_r, temp_nxt;
  logic [11:0] soak_r, soak_nxt;
  logic        ten_r, ten_nxt;
  logic        press_r, press_nxt;
  logic [15:0] held_r, held_nxt;
  logic [15:0] since_r, since_nxt;
  logic        level_r, level_nxt;
  pulses_t     pulses;

  logic signed [9:0]  temp_sum;
  logic signed [13:0] soak_sum;
  logic               counts;

  assign temp_sum = $signed({2'b00, temp_r}) + $signed({{2{item.enc_delta[7]}}, item.enc_delta});
  assign soak_sum = $signed({2'b00, soak_r})
                  + $signed({{3{item.enc_delta[7]}}, item.enc_delta, 3'b000})
                  + $signed({{5{item.enc_delta[7]}}, item.enc_delta, 1'b0});
  assign counts = since_r > {6'd0, debounce_r};

  always_comb begin
    ui_mode_nxt = ui_mode_r;
    temp_nxt    = temp_r;
    soak_nxt    = soak_r;
    ten_nxt     = ten_r;
    press_nxt   = press_r;
    held_nxt    = held_r;
    since_nxt   = since_r;
    level_nxt   = level_r;
    pulses      = '0;
    case (item.mode)
      MODE_TICK: begin
        if (since_r != SAT16) since_nxt = since_r + 16'd1;
        if (press_r && held_r != SAT16) held_nxt = held_r + 16'd1;
        if (press_r && level_r && held_nxt > {2'b00, long_press_r}) begin
          pulses.long_beep = 1'b1;
          if (ui_mode_r == ST_READY || ui_mode_r == ST_HEATING || ui_mode_r == ST_SOAKING) begin
            ui_mode_nxt         = ST_STOPPED;
            pulses.stop_heating = 1'b1;
          end
          press_nxt = 1'b0;
        end
      end
      MODE_ENC: begin
        if (item.enc_delta != 8'd0) begin
          if (ui_mode_r == ST_SET_TEMP) begin
            if (temp_sum < $signed({2'b00, TEMP_MIN})) temp_nxt = TEMP_MIN;
            else if (temp_sum > $signed({2'b00, TEMP_MAX})) temp_nxt = TEMP_MAX;
            else temp_nxt = temp_sum[7:0];
          end else if (ui_mode_r == ST_SET_TIME) begin
            if (soak_sum < 14'sd0) soak_nxt = 12'd0;
            else if (soak_sum > $signed({2'b00, SOAK_MAX})) soak_nxt = SOAK_MAX;
            else soak_nxt = soak_sum[11:0];
          end else if (ui_mode_r == ST_SET_TIMER) begin
            ten_nxt = ~ten_r;
          end
        end
      end
      MODE_BTN: begin
        since_nxt = 16'd0;
        level_nxt = item.button_down;
        if (counts) begin
          if (item.button_down && !press_r) begin
            press_nxt = 1'b1;
            held_nxt  = 16'd0;
          end else if (!item.button_down && press_r) begin
            press_nxt         = 1'b0;
            pulses.short_beep = 1'b1;
            case (ui_mode_r)
              ST_OFF, ST_DONE, ST_STOPPED, ST_ERROR: ui_mode_nxt = ST_SET_TEMP;
              ST_SET_TEMP: ui_mode_nxt = ST_SET_TIME;
              ST_SET_TIME: ui_mode_nxt = ST_SET_TIMER;
              ST_SET_TIMER: begin
                pulses.save_settings = 1'b1;
                ui_mode_nxt          = ST_READY;
              end
              ST_READY: begin
                pulses.start_heating = 1'b1;
                ui_mode_nxt          = ST_HEATING;
              end
              ST_SOAKING: begin
                if (ten_r && item.soak_running) pulses.restart_soak = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end
      MODE_STATE: begin
        if (item.new_state <= ST_ERROR) ui_mode_nxt = item.new_state;
      end
      MODE_LOAD: begin
        if (item.load_temp < TEMP_MIN) temp_nxt = TEMP_MIN;
        else if (item.load_temp > TEMP_MAX) temp_nxt = TEMP_MAX;
        else temp_nxt = item.load_temp;
        if (item.load_soak_seconds > SOAK_MAX) soak_nxt = SOAK_MAX;
        else soak_nxt = item.load_soak_seconds;
        ten_nxt = item.load_timer_enabled;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RESET;
      long_press_r <= LONG_PRESS_RESET;
      ui_mode_r    <= ST_OFF;
      temp_r       <= TEMP_RESET;
      soak_r       <= 12'd0;
      ten_r        <= 1'b0;
      press_r      <= 1'b0;
      held_r       <= 16'd0;
      since_r      <= SAT16;
      level_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[9:0];
          CFG_LONG_PRESS: long_press_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (step) begin
        ui_mode_r <= ui_mode_nxt;
        temp_r    <= temp_nxt;
        soak_r    <= soak_nxt;
        ten_r     <= ten_nxt;
        press_r   <= press_nxt;
        held_r    <= held_nxt;
        since_r   <= since_nxt;
        level_r   <= level_nxt;
      end
    end
  end

  assign res.ui_state      = ui_mode_nxt;
  assign res.target_temp   = temp_nxt;
  assign res.soak_seconds  = soak_nxt;
  assign res.timer_enabled = ten_nxt;
  assign res.pulses        = pulses;

endmodule

// ----- hw/rtl/kbmc_out_stage.sv -----
// ----------------------------------------------------------------------------
// kbmc_out_stage: result register
// Holds one result until it is taken and splits the soak time into minutes
// and seconds for display.
// ----------------------------------------------------------------------------
module kbmc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  kbmc_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [3:0]        out_ui_state,
  output logic [7:0]        out_target_temp,
  output logic [5:0]        out_soak_minutes,
  output logic [5:0]        out_soak_secs,
  output logic              out_timer_enabled,
  output logic              out_short_beep,
  output logic              out_long_beep,
  output logic              out_save_settings,
  output logic              out_start_heating,
  output logic              out_restart_soak,
  output logic              out_stop_heating
);
  import kbmc_pkg::*;

  logic    valid_r;
  result_t res_r;
  logic [24:0] prod;
  logic [5:0]  minutes;
  logic [11:0] min_times_60;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign prod         = 25'(res_r.soak_seconds * RECIP_60);
  assign minutes      = prod[23:18];
  assign min_times_60 = 12'(minutes * SECS_PER_MIN);

  assign out_valid         = valid_r;
  assign out_ui_state      = res_r.ui_state;
  assign out_target_temp   = res_r.target_temp;
  assign out_soak_minutes  = minutes;
  assign out_soak_secs     = 6'(res_r.soak_seconds - min_times_60);
  assign out_timer_enabled = res_r.timer_enabled;
  assign out_short_beep    = res_r.pulses.short_beep;
  assign out_long_beep     = res_r.pulses.long_beep;
  assign out_save_settings = res_r.pulses.save_settings;
  assign out_start_heating = res_r.pulses.start_heating;
  assign out_restart_soak  = res_r.pulses.restart_soak;
  assign out_stop_heating  = res_r.pulses.stop_heating;

endmodule

// ----- hw/rtl/knob_button_menu_controller.sv -----
// ----------------------------------------------------------------------------
// knob_button_menu_controller: front-panel menu controller of a heater
// Events from the tick source, the encoder, the button and the heater logic
// enter on the in_ channel; each item gives exactly one result on the out_
// channel with the menu state, the settings and the event pulses.
// Both channels use valid and ready. An accepted item is captured in the input
// register, is applied to the menu state as it moves into the result register,
// and shows on the out_ ports from there. One item per cycle is sustained
// while out_ready stays high; the single state update path from the input
// register to the result register sets that figure.
// If the receiver stalls, the result register holds its item and the input
// register takes one more; in_ready then drops until the result is taken.
// Reset clears both registers, restores the default settings and the
// configuration registers; the cfg_ port writes debounce and long press times
// at any edge with cfg_we high outside reset.
// ----------------------------------------------------------------------------
module knob_button_menu_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [13:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_enc_delta,
  input  logic        in_button_down,
  input  logic        in_soak_running,
  input  logic [3:0]  in_new_state,
  input  logic [7:0]  in_load_temp,
  input  logic [11:0] in_load_soak_seconds,
  input  logic        in_load_timer_enabled,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_ui_state,
  output logic [7:0]  out_target_temp,
  output logic [5:0]  out_soak_minutes,
  output logic [5:0]  out_soak_secs,
  output logic        out_timer_enabled,
  output logic        out_short_beep,
  output logic        out_long_beep,
  output logic        out_save_settings,
  output logic        out_start_heating,
  output logic        out_restart_soak,
  output logic        out_stop_heating
);
  import kbmc_pkg::*;

  logic    in_valid_r;
  item_t   item_r;
  result_t res;
  logic    advance;

  assign advance  = in_valid_r && (!out_valid || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.mode               <= in_mode;
      item_r.enc_delta          <= in_enc_delta;
      item_r.button_down        <= in_button_down;
      item_r.soak_running       <= in_soak_running;
      item_r.new_state          <= in_new_state;
      item_r.load_temp          <= in_load_temp;
      item_r.load_soak_seconds  <= in_load_soak_seconds;
      item_r.load_timer_enabled <= in_load_timer_enabled;
    end
  end

  kbmc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (item_r),
    .res       (res)
  );

  kbmc_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (advance),
    .res               (res),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_ui_state      (out_ui_state),
    .out_target_temp   (out_target_temp),
    .out_soak_minutes  (out_soak_minutes),
    .out_soak_secs     (out_soak_secs),
    .out_timer_enabled (out_timer_enabled),
    .out_short_beep    (out_short_beep),
    .out_long_beep     (out_long_beep),
    .out_save_settings (out_save_settings),
    .out_start_heating (out_start_heating),
    .out_restart_soak  (out_restart_soak),
    .out_stop_heating  (out_stop_heating)
  );

endmodule
